### sv/greedy_balanced_kway_partition_assert.svh
// assertion macros for the greedy balanced k-way partition block
`ifndef GREEDY_BALANCED_KWAY_PARTITION_ASSERT_SVH
`define GREEDY_BALANCED_KWAY_PARTITION_ASSERT_SVH

// property holds at every clock edge out of reset
`define GBKP_ASSERT_HOLDS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gbkp assertion failed");

// antecedent implies consequent in the next cycle
`define GBKP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gbkp assertion failed");

`endif

### sv/gbkp_pkg.sv
// package with constants and types of the greedy balanced k-way partition block
`timescale 1ns / 1ps
package gbkp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_PARTS    = 8;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_W   = $clog2(MAX_VERTICES);
  localparam int PART_W  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_W   = VTX_W + 1;
  localparam int KCNT_W  = PART_W + 1;
  localparam int ADDR_W  = 2 * VTX_W;
  localparam int GAIN_W  = WEIGHT_BITS + VTX_W + 2;
  localparam int PROD_W  = CNT_W + KCNT_W;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int VC_W    = 7;
  localparam int PC_W    = 4;
  localparam int CFG_D_W = 7;
  localparam int CFG_I_W = 1;

  localparam logic [CFG_I_W-1:0] CFG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_I_W-1:0] CFG_PART_COUNT   = 1'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic                     have;
    logic signed [GAIN_W-1:0] gain;
    logic [VTX_W-1:0]         vertex;
  } cand_t;

  typedef cand_t [MAX_PARTS-1:0] cand_vec_t;

  typedef struct packed {
    logic             clear;
    logic             place;
    logic [VTX_W-1:0] place_v;
    logic [CNT_W-1:0] n;
  } ctl_t;

  typedef struct packed {
    logic                   vld;
    logic [VTX_W-1:0]       idx;
    logic [WEIGHT_BITS-1:0] weight;
    logic [PART_W-1:0]      part;
  } upd_t;

endpackage

### sv/gbkp_if.sv
// request, output and configuration channel interfaces of the partition block
`timescale 1ns / 1ps
interface gbkp_in_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [gbkp_pkg::ROW_W-1:0]      row;
  logic [gbkp_pkg::COL_W-1:0]      col;
  logic signed [gbkp_pkg::WEIGHT_BITS-1:0] weight;
  modport source (output valid, command, row, col, weight, input ready);
  modport sink (input valid, command, row, col, weight, output ready);
endinterface

interface gbkp_out_if;
  logic                         valid;
  logic                         ready;
  logic [gbkp_pkg::VTX_W-1:0]   vertex;
  logic [gbkp_pkg::PART_W-1:0]  assigned_part;
  logic                         last;
  modport source (output valid, vertex, assigned_part, last, input ready);
  modport sink (input valid, vertex, assigned_part, last, output ready);
endinterface

interface gbkp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbkp_pkg::CFG_I_W-1:0]   index;
  logic [gbkp_pkg::CFG_D_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/gbkp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module gbkp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### sv/gbkp_cell.sv
// vertex cell: per-part gains, placed flag and one stage of the min chain
`timescale 1ns / 1ps
module gbkp_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gbkp_pkg::VTX_W-1:0]  idx_i,
  input  gbkp_pkg::ctl_t              ctl_i,
  input  gbkp_pkg::upd_t              upd_i,
  input  gbkp_pkg::cand_vec_t         cand_i,
  output gbkp_pkg::cand_vec_t         cand_o
);
  logic signed [gbkp_pkg::GAIN_W-1:0] gain_q [gbkp_pkg::MAX_PARTS];
  logic                               placed_q;
  logic signed [gbkp_pkg::GAIN_W-1:0] wx;
  logic                               active;
  gbkp_pkg::cand_vec_t                cand_d;
  gbkp_pkg::cand_vec_t                cand_q;

  assign wx = {{(gbkp_pkg::GAIN_W - gbkp_pkg::WEIGHT_BITS){upd_i.weight[gbkp_pkg::WEIGHT_BITS-1]}},
               upd_i.weight};
  assign active = !placed_q && ({1'b0, idx_i} < ctl_i.n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
    end else if (ctl_i.clear) begin
      placed_q <= 1'b0;
    end else if (ctl_i.place && ctl_i.place_v == idx_i) begin
      placed_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < gbkp_pkg::MAX_PARTS; p++) begin
      if (ctl_i.clear) begin
        gain_q[p] <= '0;
      end else if (upd_i.vld && upd_i.idx == idx_i && !placed_q) begin
        if (gbkp_pkg::PART_W'(p) == upd_i.part) begin
          gain_q[p] <= gain_q[p] - wx;
        end else begin
          gain_q[p] <= gain_q[p] + wx;
        end
      end
    end
  end

  // keep the incoming candidate unless this vertex is strictly better
  always_comb begin
    for (int p = 0; p < gbkp_pkg::MAX_PARTS; p++) begin
      if (active && (!cand_i[p].have || gain_q[p] < cand_i[p].gain)) begin
        cand_d[p].have   = 1'b1;
        cand_d[p].gain   = gain_q[p];
        cand_d[p].vertex = idx_i;
      end else begin
        cand_d[p] = cand_i[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;
endmodule

### sv/greedy_balanced_kway_partition.sv
// a load request writes one edge weight when taken, back to back while idle;
// a run emits n placements, each with n weight reads from the edge ram port,
// then, but for the last, the candidate wave through the MAX_VERTICES cells
// a run occupies the block; new requests are taken once the last placement is out
// reset: asynchronous active low, vertex_count 64, part_count 4, block idle
// edge weights are not cleared; gains, placed flags and part sizes clear per run
`timescale 1ns / 1ps
module greedy_balanced_kway_partition (
  input  logic          clk_i,
  input  logic          rst_ni,
  gbkp_in_if.sink       in_i,
  gbkp_out_if.source    out_o,
  gbkp_cfg_if.sink      cfg_i
);
  `include "greedy_balanced_kway_partition_assert.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PLACE  = 3'd1;
  localparam logic [2:0] S_UPD    = 3'd2;
  localparam logic [2:0] S_UPDW   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_SRCH   = 3'd5;
  localparam logic [2:0] S_CHOOSE = 3'd6;

  logic [2:0]                         state_q, state_d;
  logic [gbkp_pkg::VC_W-1:0]          vc_q;
  logic [gbkp_pkg::PC_W-1:0]          pc_q;
  logic [gbkp_pkg::CNT_W-1:0]         n_q, n_d;
  logic [gbkp_pkg::KCNT_W-1:0]        k_q, k_d;
  logic [gbkp_pkg::CNT_W-1:0]         placed_q;
  logic [gbkp_pkg::CNT_W-1:0]         size_q [gbkp_pkg::MAX_PARTS];
  logic [gbkp_pkg::VTX_W-1:0]         v_q;
  logic [gbkp_pkg::PART_W-1:0]        a_q;
  logic [gbkp_pkg::VTX_W-1:0]         i_q;
  logic [gbkp_pkg::CNT_W-1:0]         wait_q;
  logic                               upd_vld_q;
  logic [gbkp_pkg::VTX_W-1:0]         upd_idx_q;
  logic                               out_vld_q;
  logic [gbkp_pkg::VTX_W-1:0]         out_v_q;
  logic [gbkp_pkg::PART_W-1:0]        out_a_q;
  logic                               out_last_q;
  logic                               in_acc, run_acc, load_acc, out_load, is_last;
  logic [gbkp_pkg::WEIGHT_BITS-1:0]   rdata;
  gbkp_pkg::ctl_t                     ctl;
  gbkp_pkg::upd_t                     upd;
  gbkp_pkg::cand_vec_t                chain [gbkp_pkg::MAX_VERTICES+1];
  gbkp_pkg::cand_vec_t                best;
  logic [gbkp_pkg::PART_W-1:0]        pick;
  logic                               pick_have;
  logic signed [gbkp_pkg::GAIN_W-1:0] pick_gain;
  logic [gbkp_pkg::PROD_W-1:0]        prod;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc   = in_i.valid && in_i.ready;
  assign run_acc  = in_acc && in_i.command == gbkp_pkg::CMD_RUN;
  assign load_acc = in_acc && in_i.command == gbkp_pkg::CMD_LOAD;
  assign out_load = (state_q == S_EMIT) && (!out_vld_q || out_o.ready);
  assign is_last  = (placed_q == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= gbkp_pkg::VC_W'(64);
      pc_q <= gbkp_pkg::PC_W'(4);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        gbkp_pkg::CFG_VERTEX_COUNT: vc_q <= cfg_i.data[gbkp_pkg::VC_W-1:0];
        gbkp_pkg::CFG_PART_COUNT:   pc_q <= cfg_i.data[gbkp_pkg::PC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (vc_q == '0) begin
      n_d = gbkp_pkg::CNT_W'(1);
    end else if (gbkp_pkg::CNT_W'(vc_q) > gbkp_pkg::CNT_W'(gbkp_pkg::MAX_VERTICES)) begin
      n_d = gbkp_pkg::CNT_W'(gbkp_pkg::MAX_VERTICES);
    end else begin
      n_d = gbkp_pkg::CNT_W'(vc_q);
    end
    priority if (pc_q == '0) begin
      k_d = gbkp_pkg::KCNT_W'(1);
    end else if (pc_q > gbkp_pkg::PC_W'(gbkp_pkg::MAX_PARTS)) begin
      k_d = gbkp_pkg::KCNT_W'(gbkp_pkg::MAX_PARTS);
    end else begin
      k_d = gbkp_pkg::KCNT_W'(pc_q);
    end
  end

  gbkp_ram #(
    .WIDTH(gbkp_pkg::WEIGHT_BITS),
    .DEPTH(gbkp_pkg::MAX_VERTICES * gbkp_pkg::MAX_VERTICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i ({in_i.row[gbkp_pkg::VTX_W-1:0], in_i.col[gbkp_pkg::VTX_W-1:0]}),
    .wdata_i (in_i.weight),
    .raddr_i ({i_q, v_q}),
    .rdata_o (rdata)
  );

  assign ctl.clear   = run_acc;
  assign ctl.place   = (state_q == S_PLACE);
  assign ctl.place_v = v_q;
  assign ctl.n       = n_q;
  assign upd.vld     = upd_vld_q;
  assign upd.idx     = upd_idx_q;
  assign upd.weight  = rdata;
  assign upd.part    = a_q;

  assign chain[0] = '0;
  for (genvar g = 0; g < gbkp_pkg::MAX_VERTICES; g++) begin : g_cell
    gbkp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (gbkp_pkg::VTX_W'(g)),
      .ctl_i  (ctl),
      .upd_i  (upd),
      .cand_i (chain[g]),
      .cand_o (chain[g+1])
    );
  end
  assign best = chain[gbkp_pkg::MAX_VERTICES];

  // balanced part with the least candidate gain, lowest part on ties
  always_comb begin
    pick      = '0;
    pick_have = 1'b0;
    pick_gain = '0;
    prod      = '0;
    for (int p = 0; p < gbkp_pkg::MAX_PARTS; p++) begin
      prod = gbkp_pkg::PROD_W'(size_q[p]) * gbkp_pkg::PROD_W'(k_q);
      if (gbkp_pkg::KCNT_W'(p) < k_q && prod <= gbkp_pkg::PROD_W'(placed_q) &&
          (!pick_have || best[p].gain < pick_gain)) begin
        pick      = gbkp_pkg::PART_W'(p);
        pick_have = 1'b1;
        pick_gain = best[p].gain;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (run_acc) state_d = S_PLACE;
      S_PLACE:  state_d = S_UPD;
      S_UPD:    if ({1'b0, i_q} == n_q - gbkp_pkg::CNT_W'(1)) state_d = S_UPDW;
      S_UPDW:   state_d = S_EMIT;
      S_EMIT:   if (out_load) state_d = is_last ? S_IDLE : S_SRCH;
      S_SRCH:   if (wait_q == gbkp_pkg::CNT_W'(gbkp_pkg::MAX_VERTICES)) state_d = S_CHOOSE;
      S_CHOOSE: state_d = S_PLACE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= gbkp_pkg::CNT_W'(1);
      k_q       <= gbkp_pkg::KCNT_W'(1);
      placed_q  <= '0;
      v_q       <= '0;
      a_q       <= '0;
      i_q       <= '0;
      wait_q    <= '0;
      upd_vld_q <= 1'b0;
      upd_idx_q <= '0;
      out_vld_q <= 1'b0;
      for (int p = 0; p < gbkp_pkg::MAX_PARTS; p++) begin
        size_q[p] <= '0;
      end
    end else begin
      state_q   <= state_d;
      upd_vld_q <= (state_q == S_UPD);
      upd_idx_q <= i_q;
      if (run_acc) begin
        n_q      <= n_d;
        k_q      <= k_d;
        placed_q <= '0;
        v_q      <= '0;
        a_q      <= '0;
        for (int p = 0; p < gbkp_pkg::MAX_PARTS; p++) begin
          size_q[p] <= '0;
        end
      end
      if (state_q == S_PLACE) begin
        size_q[a_q] <= size_q[a_q] + gbkp_pkg::CNT_W'(1);
        placed_q    <= placed_q + gbkp_pkg::CNT_W'(1);
        i_q         <= '0;
      end
      if (state_q == S_UPD) begin
        i_q <= i_q + gbkp_pkg::VTX_W'(1);
      end
      if (state_q == S_EMIT) begin
        wait_q <= '0;
      end
      if (state_q == S_SRCH) begin
        wait_q <= wait_q + gbkp_pkg::CNT_W'(1);
      end
      if (state_q == S_CHOOSE) begin
        v_q <= best[pick].vertex;
        a_q <= pick;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_v_q    <= v_q;
      out_a_q    <= a_q;
      out_last_q <= is_last;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.vertex        = out_v_q;
  assign out_o.assigned_part = out_a_q;
  assign out_o.last          = out_last_q;

  `GBKP_ASSERT_HOLDS(a_placed_bound, placed_q <= n_q)
  `GBKP_ASSERT_NEXT(a_last_to_idle, out_load && is_last, state_q == S_IDLE && out_vld_q)
  `GBKP_ASSERT_HOLDS(a_choose_has_cand, state_q != S_CHOOSE || (pick_have && best[pick].have))
endmodule
